// ===== sv/lmcs_pkg.sv =====
`timescale 1ns / 1ps

package lmcs_pkg;

  // Model dimensions.
  localparam int NUM_BINS         = 16;
  localparam int BIN_W            = $clog2(NUM_BINS);
  localparam int FRAC_BITS        = 11;
  localparam int CHROMA_FRAC_BITS = 11;
  localparam int MAX_BIT_DEPTH    = 12;
  localparam int MIN_BIT_DEPTH    = 8;

  // Field widths.
  localparam int LUMA_W   = 12;
  localparam int DEPTH_W  = 4;
  localparam int CW_W     = 16;
  localparam int CSCALE_W = 16;
  localparam int CFG_W    = 64;

  // Derived widths.
  localparam int PIV_W    = CW_W + BIN_W;
  localparam int ORG_W    = MAX_BIT_DEPTH - BIN_W + 1;
  localparam int FRAC_MAX = (FRAC_BITS > CHROMA_FRAC_BITS) ? FRAC_BITS : CHROMA_FRAC_BITS;
  localparam int NUM_W    = ORG_W + FRAC_MAX;
  localparam int QUO_W    = NUM_W;
  localparam int DIV_W    = CW_W + 1;
  localparam int PROD_W   = QUO_W + LUMA_W;

  localparam logic [CSCALE_W-1:0] CSCALE_MAX  = {CSCALE_W{1'b1}};
  localparam logic [CSCALE_W-1:0] CSCALE_UNIT = CSCALE_W'(1 << CHROMA_FRAC_BITS);
  localparam logic [PROD_W:0]     ROUND_HALF  = (PROD_W+1)'(1 << (FRAC_BITS - 1));
  localparam logic [BIN_W-1:0]    LAST_BIN    = BIN_W'(NUM_BINS - 1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LUMA_BIT_DEPTH = 3'd0,
    REG_MIN_BIN        = 3'd1,
    REG_MAX_BIN        = 3'd2,
    REG_DELTAS_0_3     = 3'd3,
    REG_DELTAS_4_7     = 3'd4,
    REG_DELTAS_8_11    = 3'd5,
    REG_DELTAS_12_15   = 3'd6,
    REG_CHROMA_OFFSET  = 3'd7
  } cfg_reg_e;

  // Configuration as seen by the table builder.
  typedef struct packed {
    logic [DEPTH_W-1:0]               depth;
    logic [BIN_W-1:0]                 min_bin;
    logic [BIN_W-1:0]                 max_bin;
    logic [NUM_BINS-1:0][CW_W-1:0]    delta;
    logic signed [3:0]                chroma_offset;
  } cfg_t;

  // One bin of the piecewise-linear model.
  typedef struct packed {
    logic [PIV_W-1:0]    pivot_lo;
    logic [QUO_W-1:0]    inv_scale;
    logic [CSCALE_W-1:0] chroma_scale;
  } bin_entry_t;

  // Bit depth limited to the supported range.
  function automatic logic [DEPTH_W-1:0] clamp_depth(logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d < DEPTH_W'(MIN_BIT_DEPTH)) r = DEPTH_W'(MIN_BIT_DEPTH);
    if (d > DEPTH_W'(MAX_BIT_DEPTH)) r = DEPTH_W'(MAX_BIT_DEPTH);
    return r;
  endfunction

  // Default codeword 2^depth / NUM_BINS for a clamped depth.
  function automatic logic [ORG_W-1:0] org_cw(logic [DEPTH_W-1:0] d);
    return ORG_W'(1) << (d - DEPTH_W'(BIN_W));
  endfunction

endpackage

// ===== sv/lmcs_table_builder.sv =====
`timescale 1ns / 1ps

// Rebuilds pivots, inverse slopes and chroma scales of all bins after reset
// and after every configuration write, one bin at a time with two restoring
// dividers that produce one quotient bit per cycle.
module lmcs_table_builder (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    restart_i,
  input  lmcs_pkg::cfg_t          cfg_i,
  output logic                    ready_o,
  output logic [lmcs_pkg::PIV_W-1:0] pivot_hi_o [lmcs_pkg::NUM_BINS],
  output lmcs_pkg::bin_entry_t    entry_o [lmcs_pkg::NUM_BINS]
);

  localparam int CNT_W = $clog2(lmcs_pkg::NUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e                           state_q;
  logic                             ready_q;
  logic [lmcs_pkg::BIN_W-1:0]       bin_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic [lmcs_pkg::PIV_W-1:0]       acc_q;
  logic [lmcs_pkg::NUM_W-1:0]       na_q, nb_q;
  logic [lmcs_pkg::DIV_W-1:0]       rem_a_q, rem_b_q;
  logic [lmcs_pkg::QUO_W-1:0]       qa_q, qb_q;
  logic [lmcs_pkg::CW_W-1:0]        da_q;
  logic [lmcs_pkg::DIV_W-1:0]       db_q;
  logic                             cw_zero_q, chr_neg_q;

  logic [lmcs_pkg::DEPTH_W-1:0]     depth;
  logic [lmcs_pkg::ORG_W-1:0]       org;
  logic [lmcs_pkg::CW_W-1:0]        cw;
  logic signed [lmcs_pkg::DIV_W:0]  sdiv;
  logic [lmcs_pkg::DIV_W:0]         sh_a, sh_b;
  logic [lmcs_pkg::DIV_W-1:0]       rem_a_d, rem_b_d;
  logic [lmcs_pkg::QUO_W-1:0]       qa_d, qb_d;
  logic [lmcs_pkg::CSCALE_W-1:0]    chr_val;
  logic                             last_step;

  // Codeword of the bin being loaded.
  always_comb begin
    depth = lmcs_pkg::clamp_depth(cfg_i.depth);
    org   = lmcs_pkg::org_cw(depth);
    if (bin_q >= cfg_i.min_bin && bin_q <= cfg_i.max_bin) begin
      cw = cfg_i.delta[bin_q] + lmcs_pkg::CW_W'(org);
    end else begin
      cw = '0;
    end
    sdiv = $signed({2'b00, cw}) +
           $signed({{(lmcs_pkg::DIV_W - 3){cfg_i.chroma_offset[3]}}, cfg_i.chroma_offset});
  end

  // One restoring step of each divider.
  always_comb begin
    sh_a = {rem_a_q, na_q[lmcs_pkg::NUM_W-1]};
    sh_b = {rem_b_q, nb_q[lmcs_pkg::NUM_W-1]};
    if (sh_a >= {2'b00, da_q}) begin
      rem_a_d = lmcs_pkg::DIV_W'(sh_a - {2'b00, da_q});
      qa_d    = {qa_q[lmcs_pkg::QUO_W-2:0], 1'b1};
    end else begin
      rem_a_d = sh_a[lmcs_pkg::DIV_W-1:0];
      qa_d    = {qa_q[lmcs_pkg::QUO_W-2:0], 1'b0};
    end
    if (sh_b >= {1'b0, db_q}) begin
      rem_b_d = lmcs_pkg::DIV_W'(sh_b - {1'b0, db_q});
      qb_d    = {qb_q[lmcs_pkg::QUO_W-2:0], 1'b1};
    end else begin
      rem_b_d = sh_b[lmcs_pkg::DIV_W-1:0];
      qb_d    = {qb_q[lmcs_pkg::QUO_W-2:0], 1'b0};
    end
    last_step = (cnt_q == CNT_W'(lmcs_pkg::NUM_W - 1));
    if (cw_zero_q) begin
      chr_val = lmcs_pkg::CSCALE_UNIT;
    end else if (chr_neg_q || qb_d > lmcs_pkg::QUO_W'(lmcs_pkg::CSCALE_MAX)) begin
      chr_val = lmcs_pkg::CSCALE_MAX;
    end else begin
      chr_val = qb_d[lmcs_pkg::CSCALE_W-1:0];
    end
  end

  // Sequencer over the bins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ready_q <= 1'b0;
      bin_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else if (restart_i) begin
      state_q <= ST_LOAD;
      ready_q <= 1'b0;
      bin_q   <= '0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          acc_q   <= acc_q + lmcs_pkg::PIV_W'(cw);
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            if (bin_q == lmcs_pkg::LAST_BIN) begin
              state_q <= ST_IDLE;
              ready_q <= 1'b1;
            end else begin
              bin_q   <= bin_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider operands and the bin tables.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      na_q      <= lmcs_pkg::NUM_W'(org) << lmcs_pkg::FRAC_BITS;
      nb_q      <= lmcs_pkg::NUM_W'(org) << lmcs_pkg::CHROMA_FRAC_BITS;
      rem_a_q   <= '0;
      rem_b_q   <= '0;
      qa_q      <= '0;
      qb_q      <= '0;
      da_q      <= cw;
      db_q      <= sdiv[lmcs_pkg::DIV_W-1:0];
      cw_zero_q <= (cw == '0);
      chr_neg_q <= sdiv[lmcs_pkg::DIV_W] || (sdiv == '0);
      pivot_hi_o[bin_q]        <= acc_q + lmcs_pkg::PIV_W'(cw);
      entry_o[bin_q].pivot_lo  <= acc_q;
    end else if (state_q == ST_DIV) begin
      na_q    <= na_q << 1;
      nb_q    <= nb_q << 1;
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
      qa_q    <= qa_d;
      qb_q    <= qb_d;
      if (last_step) begin
        entry_o[bin_q].inv_scale    <= cw_zero_q ? '0 : qa_d;
        entry_o[bin_q].chroma_scale <= chr_val;
      end
    end
  end

  assign ready_o = ready_q && !restart_i;

endmodule

// ===== sv/lmcs_inverse_luma_map_unit.sv =====
`timescale 1ns / 1ps

// Inverse luma mapping for luma mapping with chroma scaling.
// Input channel: in_valid_i / in_ready_o with one mapped luma sample.
// Output channel: out_valid_o / out_ready_i with the inverse-mapped luma,
// the bin index of the sample and the chroma residual scale of that bin.
// Configuration channel: cfg_valid_i / cfg_ready_o with a register index and
// 64-bit data; a transfer is always taken.
// A sample passes four register stages (bin search, table read, multiply,
// round and clip) before its result appears; one sample per cycle is taken
// in steady state while the receiver does not stall and no rebuild runs.
// After reset and after every configuration transfer the bin tables are
// rebuilt by two bit-serial dividers, one bin after another; in_ready_o
// stays low until the rebuild is done.
// When the receiver stalls, each stage holds its item and the pipeline keeps
// filling its empty stages; apart from a table rebuild, in_ready_o drops
// only when the stage in front is full and cannot move.
module lmcs_inverse_luma_map_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lmcs_pkg::LUMA_W-1:0]       luma_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lmcs_pkg::LUMA_W-1:0]       inverse_luma_o,
  output logic [lmcs_pkg::BIN_W-1:0]        bin_index_o,
  output logic [lmcs_pkg::CSCALE_W-1:0]     chroma_scale_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [lmcs_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int SUM_W = lmcs_pkg::PROD_W + 1 - lmcs_pkg::FRAC_BITS;

  // Configuration registers.
  logic [lmcs_pkg::DEPTH_W-1:0]    depth_q;
  logic [lmcs_pkg::BIN_W-1:0]      min_bin_q, max_bin_q;
  logic [3:0][lmcs_pkg::CFG_W-1:0] delta_q;
  logic signed [3:0]               chroma_offset_q;
  logic                            cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q         <= lmcs_pkg::DEPTH_W'(10);
      min_bin_q       <= '0;
      max_bin_q       <= lmcs_pkg::LAST_BIN;
      delta_q         <= '0;
      chroma_offset_q <= '0;
    end else if (cfg_fire) begin
      unique case (lmcs_pkg::cfg_reg_e'(cfg_index_i))
        lmcs_pkg::REG_LUMA_BIT_DEPTH: depth_q   <= cfg_data_i[lmcs_pkg::DEPTH_W-1:0];
        lmcs_pkg::REG_MIN_BIN:        min_bin_q <= cfg_data_i[lmcs_pkg::BIN_W-1:0];
        lmcs_pkg::REG_MAX_BIN:        max_bin_q <= cfg_data_i[lmcs_pkg::BIN_W-1:0];
        lmcs_pkg::REG_DELTAS_0_3:     delta_q[0] <= cfg_data_i;
        lmcs_pkg::REG_DELTAS_4_7:     delta_q[1] <= cfg_data_i;
        lmcs_pkg::REG_DELTAS_8_11:    delta_q[2] <= cfg_data_i;
        lmcs_pkg::REG_DELTAS_12_15:   delta_q[3] <= cfg_data_i;
        lmcs_pkg::REG_CHROMA_OFFSET:  chroma_offset_q <= cfg_data_i[3:0];
        default:                      depth_q   <= depth_q;
      endcase
    end
  end

  // Bin tables.
  lmcs_pkg::cfg_t       cfg;
  logic                 tbl_ready;
  logic [lmcs_pkg::PIV_W-1:0] pivot_hi [lmcs_pkg::NUM_BINS];
  lmcs_pkg::bin_entry_t entry [lmcs_pkg::NUM_BINS];

  always_comb begin
    cfg.depth         = depth_q;
    cfg.min_bin       = min_bin_q;
    cfg.max_bin       = max_bin_q;
    cfg.delta         = delta_q;
    cfg.chroma_offset = chroma_offset_q;
  end

  lmcs_table_builder u_builder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_fire),
    .cfg_i      (cfg),
    .ready_o    (tbl_ready),
    .pivot_hi_o (pivot_hi),
    .entry_o    (entry)
  );

  // Stage handshake: a stage moves when it is empty or the next one moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && tbl_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i && in_ready_o;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Common derived values of the bit depth.
  logic [lmcs_pkg::DEPTH_W-1:0] depth;
  logic [lmcs_pkg::LUMA_W:0]    full_range;
  logic [lmcs_pkg::LUMA_W-1:0]  maxval;

  always_comb begin
    depth      = lmcs_pkg::clamp_depth(depth_q);
    full_range = (lmcs_pkg::LUMA_W+1)'(1) << depth;
    maxval     = lmcs_pkg::LUMA_W'(full_range - 1'b1);
  end

  // Stage 1: find the bin of the sample.
  logic [lmcs_pkg::BIN_W-1:0]  idx_d, idx1_q;
  logic [lmcs_pkg::LUMA_W-1:0] luma1_q;
  logic [lmcs_pkg::NUM_BINS-1:0] hit;

  always_comb begin
    for (int i = 0; i < lmcs_pkg::NUM_BINS; i++) begin
      hit[i] = (lmcs_pkg::BIN_W'(i) >= min_bin_q) && (lmcs_pkg::BIN_W'(i) <= max_bin_q) &&
               (lmcs_pkg::PIV_W'(luma_value_i) < pivot_hi[i]);
    end
    if (max_bin_q < min_bin_q) begin
      idx_d = min_bin_q;
    end else if (max_bin_q == lmcs_pkg::LAST_BIN) begin
      idx_d = lmcs_pkg::LAST_BIN;
    end else begin
      idx_d = max_bin_q + 1'b1;
    end
    for (int i = lmcs_pkg::NUM_BINS - 1; i >= 0; i--) begin
      if (hit[i]) idx_d = lmcs_pkg::BIN_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      idx1_q  <= idx_d;
      luma1_q <= luma_value_i;
    end
  end

  // Stage 2: read the bin entry and form the offset inside the bin.
  logic [lmcs_pkg::BIN_W-1:0]    idx2_q;
  logic [lmcs_pkg::LUMA_W-1:0]   diff2_q, base2_q;
  logic [lmcs_pkg::QUO_W-1:0]    inv2_q;
  logic [lmcs_pkg::CSCALE_W-1:0] chr2_q;
  lmcs_pkg::bin_entry_t          ent;

  assign ent = entry[idx1_q];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      idx2_q  <= idx1_q;
      diff2_q <= lmcs_pkg::LUMA_W'(lmcs_pkg::PIV_W'(luma1_q) - ent.pivot_lo);
      base2_q <= lmcs_pkg::LUMA_W'(idx1_q) << (depth - lmcs_pkg::DEPTH_W'(lmcs_pkg::BIN_W));
      inv2_q  <= ent.inv_scale;
      chr2_q  <= ent.chroma_scale;
    end
  end

  // Stage 3: scale the offset by the inverse slope.
  logic [lmcs_pkg::BIN_W-1:0]    idx3_q;
  logic [lmcs_pkg::LUMA_W-1:0]   base3_q;
  logic [lmcs_pkg::PROD_W-1:0]   prod3_q;
  logic [lmcs_pkg::CSCALE_W-1:0] chr3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      idx3_q  <= idx2_q;
      base3_q <= base2_q;
      prod3_q <= lmcs_pkg::PROD_W'(inv2_q) * lmcs_pkg::PROD_W'(diff2_q);
      chr3_q  <= chr2_q;
    end
  end

  // Stage 4: round, add the bin base and clip to the bit depth.
  logic [lmcs_pkg::PROD_W:0]     rounded;
  logic [SUM_W-1:0]              sum;
  logic [lmcs_pkg::LUMA_W-1:0]   inv4_q;
  logic [lmcs_pkg::BIN_W-1:0]    idx4_q;
  logic [lmcs_pkg::CSCALE_W-1:0] chr4_q;

  always_comb begin
    rounded = ({1'b0, prod3_q} + lmcs_pkg::ROUND_HALF) >> lmcs_pkg::FRAC_BITS;
    sum     = SUM_W'(base3_q) + rounded[SUM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      inv4_q <= (sum > SUM_W'(maxval)) ? maxval : sum[lmcs_pkg::LUMA_W-1:0];
      idx4_q <= idx3_q;
      chr4_q <= chr3_q;
    end
  end

  assign out_valid_o    = v4_q;
  assign inverse_luma_o = inv4_q;
  assign bin_index_o    = idx4_q;
  assign chroma_scale_o = chr4_q;

  // A configuration transfer blocks new samples until the tables are rebuilt.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> !in_ready_o)
    else $error("sample taken right after a configuration transfer");

  // A result never exceeds the largest value of the bit depth.
  a_inverse_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inverse_luma_o <= maxval))
    else $error("inverse luma above the bit depth range");

  // A stalled output stage keeps its result.
  a_stage4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(inv4_q) && $stable(chr4_q)))
    else $error("output stage changed while stalled");

endmodule

// ===== verif/lmcs_inverse_luma_map_unit_tb.sv =====
`timescale 1ns / 1ps

module lmcs_inverse_luma_map_unit_tb;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [lmcs_pkg::LUMA_W-1:0]   luma_value_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [lmcs_pkg::LUMA_W-1:0]   inverse_luma_o;
  logic [lmcs_pkg::BIN_W-1:0]    bin_index_o;
  logic [lmcs_pkg::CSCALE_W-1:0] chroma_scale_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [2:0]                    cfg_index_i;
  logic [lmcs_pkg::CFG_W-1:0]    cfg_data_i;

  // One expected mapping result.
  typedef struct {
    logic [lmcs_pkg::LUMA_W-1:0]   inverse_luma;
    logic [lmcs_pkg::BIN_W-1:0]    bin_index;
    logic [lmcs_pkg::CSCALE_W-1:0] chroma_scale;
  } luma_map_t;

  luma_map_t expected_maps[$];

  // Shadow copy of the configuration registers.
  logic [lmcs_pkg::DEPTH_W-1:0] depth_q;
  logic [lmcs_pkg::BIN_W-1:0]   min_bin_q;
  logic [lmcs_pkg::BIN_W-1:0]   max_bin_q;
  logic [lmcs_pkg::CFG_W-1:0]   delta_words_q[4];
  logic signed [3:0]            chroma_off_q;

  bit quiet;
  int mismatches;
  int samples_sent;
  int maps_checked;
  int cfg_writes;

  lmcs_inverse_luma_map_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .luma_value_i(luma_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .inverse_luma_o(inverse_luma_o), .bin_index_o(bin_index_o),
    .chroma_scale_o(chroma_scale_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Inverse mapping of one sample under the shadow configuration.
  function automatic luma_map_t map_inverse(logic [lmcs_pkg::LUMA_W-1:0] luma);
    int unsigned   d;
    int unsigned   org;
    int unsigned   hi;
    int unsigned   idx;
    int unsigned   cw[lmcs_pkg::NUM_BINS];
    longint        piv[lmcs_pkg::NUM_BINS+1];
    logic signed [15:0] dl;
    longint        inv;
    longint        dv;
    longint        maxv;
    longint        isc;
    longint        chr;
    luma_map_t     r;
    d = depth_q;
    if (d < 8) d = 8;
    if (d > lmcs_pkg::MAX_BIT_DEPTH) d = lmcs_pkg::MAX_BIT_DEPTH;
    org = (1 << d) / lmcs_pkg::NUM_BINS;
    maxv = (1 << d) - 1;
    hi = max_bin_q;
    piv[0] = 0;
    for (int i = 0; i < lmcs_pkg::NUM_BINS; i++) begin
      if (i >= min_bin_q && i <= hi) begin
        dl = delta_words_q[i >> 2][16*(i & 3) +: 16];
        cw[i] = (int'(dl) + int'(org)) & 32'hFFFF;
      end else begin
        cw[i] = 0;
      end
      piv[i+1] = piv[i] + cw[i];
    end
    idx = min_bin_q;
    while (idx <= hi && !(longint'(luma) < piv[idx+1])) idx++;
    if (idx > lmcs_pkg::NUM_BINS - 1) idx = lmcs_pkg::NUM_BINS - 1;
    if (cw[idx] == 0) begin
      isc = 0;
      chr = 1 << lmcs_pkg::CHROMA_FRAC_BITS;
    end else begin
      dv = longint'(cw[idx]) + longint'(chroma_off_q);
      isc = (longint'(org) << lmcs_pkg::FRAC_BITS) / cw[idx];
      if (dv <= 0) chr = 65535;
      else chr = (longint'(org) << lmcs_pkg::CHROMA_FRAC_BITS) / dv;
    end
    if (chr > 65535) chr = 65535;
    inv = longint'(idx) * org
        + (isc * (longint'(luma) - piv[idx]) + (longint'(1) << (lmcs_pkg::FRAC_BITS - 1)))
          / (longint'(1) << lmcs_pkg::FRAC_BITS);
    if (inv < 0) inv = 0;
    if (inv > maxv) inv = maxv;
    r.inverse_luma = inv[lmcs_pkg::LUMA_W-1:0];
    r.bin_index    = idx[lmcs_pkg::BIN_W-1:0];
    r.chroma_scale = chr[lmcs_pkg::CSCALE_W-1:0];
    return r;
  endfunction

  // Send one sample and record its expected mapping on transfer.
  task automatic send_sample(logic [lmcs_pkg::LUMA_W-1:0] luma);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    luma_value_i <= luma;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_maps.push_back(map_inverse(luma));
    samples_sent++;
  endtask

  // Wait until every expected result has arrived, with a settling pause.
  task automatic drain_maps();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Register write, taken only once the sample results have drained and the pipeline is idle.
  task automatic write_reg(lmcs_pkg::cfg_reg_e idx, logic [lmcs_pkg::CFG_W-1:0] data);
    drain_maps();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      lmcs_pkg::REG_LUMA_BIT_DEPTH: depth_q   = data[3:0];
      lmcs_pkg::REG_MIN_BIN:        min_bin_q = data[3:0];
      lmcs_pkg::REG_MAX_BIN:        max_bin_q = data[3:0];
      lmcs_pkg::REG_DELTAS_0_3:     delta_words_q[0] = data;
      lmcs_pkg::REG_DELTAS_4_7:     delta_words_q[1] = data;
      lmcs_pkg::REG_DELTAS_8_11:    delta_words_q[2] = data;
      lmcs_pkg::REG_DELTAS_12_15:   delta_words_q[3] = data;
      lmcs_pkg::REG_CHROMA_OFFSET:  chroma_off_q = data[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random codeword delta, biased toward sensible piecewise models.
  function automatic logic [15:0] pick_delta(int org);
    int v;
    case ($urandom_range(0, 9))
      6: v = -org;
      7: v = $urandom_range(0, 16'hFFFF);
      8: v = 0;
      9: v = -org + $urandom_range(1, 8);
      default: v = int'($urandom_range(0, 2 * org)) - org;
    endcase
    return v[15:0];
  endfunction

  // Load a random but mostly well-formed model into all registers.
  task automatic load_random_model();
    logic [3:0]  d;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [63:0] w;
    int          dc;
    int          org;
    d = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(8, 12));
    dc = (d < 8) ? 8 : (d > 12) ? 12 : d;
    org = (1 << dc) / lmcs_pkg::NUM_BINS;
    lo = 4'($urandom_range(0, 15));
    hi = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 8 && lo > hi) begin
      lo = lo ^ hi;
      hi = lo ^ hi;
      lo = lo ^ hi;
    end
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'(d));
    write_reg(lmcs_pkg::REG_MIN_BIN, 64'(lo));
    write_reg(lmcs_pkg::REG_MAX_BIN, 64'(hi));
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 4; k++) w[16*k +: 16] = pick_delta(org);
      write_reg(lmcs_pkg::cfg_reg_e'(int'(lmcs_pkg::REG_DELTAS_0_3) + g), w);
    end
    write_reg(lmcs_pkg::REG_CHROMA_OFFSET, 64'($urandom_range(0, 15)));
  endtask

  // Reset configuration with the field extremes.
  task automatic test_reset_model();
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd1023);
    send_sample(12'd512);
  endtask

  // A bin with a zero codeword, and an empty bin range.
  task automatic test_zero_codeword();
    write_reg(lmcs_pkg::REG_DELTAS_0_3, {16'hFFC0, 16'd10, 16'hFFF6, 16'd0});
    send_sample(12'd100);
    send_sample(12'd192);
    send_sample(12'd300);
    write_reg(lmcs_pkg::REG_MIN_BIN, 64'd9);
    write_reg(lmcs_pkg::REG_MAX_BIN, 64'd3);
    send_sample(12'd0);
    send_sample(12'd2000);
    write_reg(lmcs_pkg::REG_MIN_BIN, 64'd0);
    write_reg(lmcs_pkg::REG_MAX_BIN, 64'd15);
  endtask

  // Bit depth at both ends of the range and beyond it.
  task automatic test_depth_extremes();
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'd8);
    send_sample(12'd255);
    send_sample(12'hFFF);
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'd12);
    send_sample(12'hFFF);
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'd0);
    send_sample(12'd200);
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'd15);
    send_sample(12'd4000);
  endtask

  // Chroma divisor below zero, and a scale that saturates.
  task automatic test_chroma_limits();
    write_reg(lmcs_pkg::REG_LUMA_BIT_DEPTH, 64'd12);
    write_reg(lmcs_pkg::REG_DELTAS_0_3, {48'd0, 16'hFF03});
    write_reg(lmcs_pkg::REG_CHROMA_OFFSET, 64'h9);
    send_sample(12'd1);
    write_reg(lmcs_pkg::REG_CHROMA_OFFSET, 64'h4);
    send_sample(12'd2);
    write_reg(lmcs_pkg::REG_CHROMA_OFFSET, 64'h7);
    send_sample(12'd4095);
    write_reg(lmcs_pkg::REG_DELTAS_0_3, 64'h7FFF_8000_7FFF_8000);
    send_sample(12'd5);
    send_sample(12'd3000);
  endtask

  // Random models, each followed by a burst of random samples.
  task automatic test_random_models();
    for (int p = 0; p < 30; p++) begin
      quiet = (p >= 12 && p < 16);
      load_random_model();
      repeat (61) send_sample(12'($urandom_range(0, 4095)));
    end
    quiet = 1'b0;
  endtask

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    luma_map_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: inv=%0d bin=%0d cs=%0d",
                   inverse_luma_o, bin_index_o, chroma_scale_o);
      end else begin
        e = expected_maps.pop_front();
        maps_checked++;
        if (e.inverse_luma !== inverse_luma_o || e.bin_index !== bin_index_o ||
            e.chroma_scale !== chroma_scale_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp inv=%0d bin=%0d cs=%0d, got inv=%0d bin=%0d cs=%0d",
                     e.inverse_luma, e.bin_index, e.chroma_scale,
                     inverse_luma_o, bin_index_o, chroma_scale_o);
        end
      end
    end
  end

  // Receiver stalls at random unless in a quiet stretch.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= quiet || ($urandom_range(0, 99) >= 7);
  end

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("lmcs_inverse_luma_map_unit regression: fail");
    $finish;
  end

  initial begin
    int waited;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    luma_value_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 1'b0;
    depth_q = 4'd10;
    min_bin_q = 4'd0;
    max_bin_q = 4'd15;
    for (int g = 0; g < 4; g++) delta_words_q[g] = '0;
    chroma_off_q = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_model();
    test_zero_codeword();
    test_depth_extremes();
    test_chroma_limits();
    test_random_models();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_maps.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_maps.size() != 0) mismatches += expected_maps.size();

    $display("Covered %0d samples, %0d results checked, %0d register writes.",
             samples_sent, maps_checked, cfg_writes);
    $display("Models included zero codewords, empty bin ranges and chroma saturation.");
    if (mismatches == 0) begin
      $display("lmcs_inverse_luma_map_unit regression: pass");
    end else begin
      $display("lmcs_inverse_luma_map_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lmcs_pkg.sv
sv/lmcs_table_builder.sv
sv/lmcs_inverse_luma_map_unit.sv
verif/lmcs_inverse_luma_map_unit_tb.sv
